[rtl/core/triangle_barycentric_pixel_shader_defines.svh]
// Assertion macros for the triangle pixel shader checker.
// Used by tbps_checker.sv; no other dependencies.
`ifndef TRIANGLE_BARYCENTRIC_PIXEL_SHADER_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_PIXEL_SHADER_DEFINES_SVH

// Implication checked outside reset.
`define TBPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbps check failed");

// Next-cycle implication checked at every edge, reset included.
`define TBPS_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tbps check failed");

`endif

[rtl/core/tbps_pkg.sv]
// Shared types and constants of the triangle pixel shader.
// No dependencies; imported by every module of the block.
`default_nettype none
package tbps_pkg;

   localparam int MAX_DIM_DEFAULT   = 4096;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int PIX_W  = 12;
   localparam int CSR_W  = 13;
   localparam int CHAN_W = 8;

   localparam logic [CSR_W-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [CSR_W-1:0]  HEIGHT_RESET = 13'd480;
   localparam logic [CHAN_W-1:0] BACKGROUND   = 8'd16;
   localparam logic [CHAN_W-1:0] OPAQUE       = 8'd255;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } pixel_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              covered;
   } pixel_rsp_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_ctrl_type;

endpackage
`default_nettype wire

[rtl/core/tbps_front.sv]
// Front end: takes pixel words and forms the clip-mapping numerators.
// Depends on tbps_pkg.
`default_nettype none
module tbps_front
   import tbps_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic           start,
   input  pixel_req_type       req_data,
   input  wire logic           queue_full,
   output queue_ctrl_type      ctrl,
   output logic [2*(PIX_W+1+FRAC_BITS)-1:0] num_pair
);
   localparam int NUM_W = PIX_W + 1 + FRAC_BITS;

   logic [NUM_W-1:0] num_x;
   logic [NUM_W-1:0] num_y;

   // (2p+1) scaled by the fraction weight: the low bits are all zero.
   assign num_x = {req_data.pixel_x, 1'b1, {FRAC_BITS{1'b0}}};
   assign num_y = {req_data.pixel_y, 1'b1, {FRAC_BITS{1'b0}}};

   assign ctrl.push = start && !queue_full;
   assign ctrl.full = queue_full;
   assign num_pair  = {num_x, num_y};
endmodule
`default_nettype wire

[rtl/core/tbps_queue.sv]
// Two-entry queue between front end and divider back end.
// Depends on tbps_pkg.
`default_nettype none
module tbps_queue
   import tbps_pkg::*;
#(
   parameter int DATA_W = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   output logic                   pop_valid,
   output logic [DATA_W-1:0]      pop_data
);
   logic [DATA_W-1:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid;   // the back end never stalls
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/tbps_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tbps_pkg.
`default_nettype none
module tbps_divider
   import tbps_pkg::*;
#(
   parameter int NUM_W = 29
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [CSR_W-1:0] den,
   output logic                  out_valid,
   output logic [NUM_W-1:0]      out_quo
);
   logic             valid_ff [NUM_W];
   logic [CSR_W-1:0] rem_ff   [NUM_W];
   logic [NUM_W-1:0] quo_ff   [NUM_W];
   logic [NUM_W-1:0] num_ff   [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic             valid_prev;
      logic [CSR_W-1:0] rem_prev;
      logic [NUM_W-1:0] quo_prev;
      logic [NUM_W-1:0] num_prev;
      logic [CSR_W:0]   trial;
      logic             take;
      logic [CSR_W-1:0] rem_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign quo_prev   = '0;
         assign num_prev   = in_num;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign quo_prev   = quo_ff[i-1];
         assign num_prev   = num_ff[i-1];
      end

      always_comb begin
         trial  = {rem_prev, num_prev[NUM_W-1]};
         take   = (trial >= {1'b0, den});
         rem_in = take ? CSR_W'(trial - {1'b0, den}) : trial[CSR_W-1:0];
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         quo_ff[i] <= {quo_prev[NUM_W-2:0], take};
         num_ff[i] <= {num_prev[NUM_W-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
endmodule
`default_nettype wire

[rtl/core/tbps_shade.sv]
// Back-end shading: barycentric weights, coverage test and colour quantising.
// Depends on tbps_pkg.
`default_nettype none
module tbps_shade
   import tbps_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [PIX_W+FRAC_BITS:0]     quo_x,
   input  wire logic [PIX_W+FRAC_BITS:0]     quo_y,
   output logic                              rsp_valid,
   output pixel_rsp_type                     rsp_data
);
   localparam int NUM_W = PIX_W + 1 + FRAC_BITS;
   localparam int SW    = NUM_W + 3;
   localparam logic signed [SW-1:0] UNIT = SW'(64'sd1 << FRAC_BITS);
   localparam logic signed [SW-1:0] HALF = SW'(64'sd1 << (FRAC_BITS - 1));
   localparam logic signed [SW-1:0] ONE2 = SW'(64'sd1 << (FRAC_BITS + 1));

   // Clamp to one, scale by 255 and round half up.
   function automatic logic [CHAN_W-1:0] quantise(input logic signed [SW-1:0] d);
      logic [FRAC_BITS+1:0] c;
      logic [FRAC_BITS+9:0] scaled;
      c      = (d > ONE2) ? ONE2[FRAC_BITS+1:0] : d[FRAC_BITS+1:0];
      scaled = {c, 8'd0} - {8'd0, c} + (FRAC_BITS+10)'(64'd1 << FRAC_BITS);
      return scaled[FRAC_BITS+8:FRAC_BITS+1];
   endfunction

   logic signed [SW-1:0] px, py;
   logic signed [SW-1:0] d0_ff, d1_ff, d2_ff;
   logic signed [SW-1:0] d0_in, d1_in, d2_in;
   logic                 wvalid_ff;
   logic                 ovalid_ff;
   pixel_rsp_type        out_ff, out_in;

   always_comb begin
      px    = signed'({3'b000, quo_x}) - UNIT;
      py    = signed'({3'b000, quo_y}) - UNIT;
      d0_in = UNIT - (py <<< 1);
      d1_in = (px <<< 1) + py + HALF;
      d2_in = py + HALF - (px <<< 1);
   end

   always_comb begin
      out_in.alpha = OPAQUE;
      if (d0_ff[SW-1] || d1_ff[SW-1] || d2_ff[SW-1]) begin
         out_in.red     = BACKGROUND;
         out_in.green   = BACKGROUND;
         out_in.blue    = BACKGROUND;
         out_in.covered = 1'b0;
      end else begin
         out_in.red     = quantise(d0_ff);
         out_in.green   = quantise(d1_ff);
         out_in.blue    = quantise(d2_ff);
         out_in.covered = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff  <= d0_in;
      d1_ff  <= d1_in;
      d2_ff  <= d2_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         wvalid_ff <= in_valid;
         ovalid_ff <= wvalid_ff;
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

[rtl/core/triangle_barycentric_pixel_shader.sv]
// Top level of the triangle pixel shader: front end, queue, dividers, shading.
// Depends on tbps_pkg, tbps_front, tbps_queue, tbps_divider and tbps_shade.
//
//   Channel  Ports                          Handshake
//   request  start, busy, req_data          taken when start high and busy low
//   result   rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//   config   csr_we, csr_index, csr_data    written when csr_we high
//
// One pixel is taken every cycle; the queue entry is written at the accepting edge,
// then the word passes through the pipelined dividers, which register each quotient bit,
// and then through the weight and output registers of the shading stages to the ports.
// Reset empties the queue and the pipeline; sizes return to 640 by 480.
// The receiver cannot stall, so busy stays low in operation.
`default_nettype none
module triangle_barycentric_pixel_shader
   import tbps_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  pixel_req_type         req_data,
   output logic                  rsp_valid,
   output pixel_rsp_type         rsp_data,
   input  wire logic             csr_we,
   input  csr_index_type         csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);
   localparam int NUM_W = PIX_W + 1 + FRAC_BITS;

   logic [CSR_W-1:0] width_ff, width_in;
   logic [CSR_W-1:0] height_ff, height_in;
   logic [CSR_W-1:0] den_x, den_y;

   queue_ctrl_type     ctrl;
   logic               queue_full;
   logic [2*NUM_W-1:0] num_pair;
   logic               q_valid;
   logic [2*NUM_W-1:0] q_data;
   logic               vx, vy;
   logic [NUM_W-1:0]   quo_x, quo_y;

   function automatic logic [CSR_W-1:0] clamp_dim(input logic [CSR_W-1:0] v);
      if (v == '0) return CSR_W'(1);
      if (int'(v) > MAX_DIM) return CSR_W'(MAX_DIM);
      return v;
   endfunction

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign den_x = clamp_dim(width_ff);
   assign den_y = clamp_dim(height_ff);
   assign busy  = ctrl.full;

   tbps_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .start      (start),
      .req_data   (req_data),
      .queue_full (queue_full),
      .ctrl       (ctrl),
      .num_pair   (num_pair)
   );

   tbps_queue #(.DATA_W(2*NUM_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ctrl.push),
      .push_data (num_pair),
      .full      (queue_full),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   tbps_divider #(.NUM_W(NUM_W)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_num    (q_data[2*NUM_W-1:NUM_W]),
      .den       (den_x),
      .out_valid (vx),
      .out_quo   (quo_x)
   );

   tbps_divider #(.NUM_W(NUM_W)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_num    (q_data[NUM_W-1:0]),
      .den       (den_y),
      .out_valid (vy),
      .out_quo   (quo_y)
   );

   tbps_shade #(.FRAC_BITS(FRAC_BITS)) u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vx && vy),
      .quo_x     (quo_x),
      .quo_y     (quo_y),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

[rtl/core/tbps_checker.sv]
// Port-level checks on the triangle pixel shader, bound to the top level.
// Depends on tbps_pkg and triangle_barycentric_pixel_shader_defines.svh.
`default_nettype none
`include "triangle_barycentric_pixel_shader_defines.svh"
module tbps_checker
   import tbps_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input pixel_rsp_type rsp_data,
   input wire logic    rsp_valid
);
   // The back end always drains, so the queue can never fill.
   `TBPS_ASSERT_IMPLY(a_never_busy, clock, reset, start, !busy)
   // Nothing leaves the pipeline in the cycle after reset.
   `TBPS_ASSERT_NEXT(a_quiet_after_reset, clock, reset, !rsp_valid)
   `TBPS_ASSERT_IMPLY(a_opaque, clock, reset, rsp_valid, rsp_data.alpha == OPAQUE)
   // An uncovered word carries the background grey on all three channels.
   `TBPS_ASSERT_IMPLY(a_background, clock, reset, rsp_valid && !rsp_data.covered,
      rsp_data.red == BACKGROUND && rsp_data.green == BACKGROUND && rsp_data.blue == BACKGROUND)
endmodule

bind triangle_barycentric_pixel_shader tbps_checker u_tbps_checker (.*);
`default_nettype wire

[tb/pixel_colour_checker.sv]
// Watches the pixel, result and register ports of the triangle pixel shader.
// Predicts each pixel colour and compares it with the block's result word.
// Depends on tbps_pkg only.
`timescale 1ns / 100ps
`default_nettype none
module pixel_colour_checker
   import tbps_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  pixel_req_type         req_data,
   input  wire logic             rsp_valid,
   input  pixel_rsp_type         rsp_data,
   input  wire logic             csr_we,
   input  csr_index_type         csr_index,
   input  wire logic [CSR_W-1:0] csr_data,
   output int                    colours_pending,
   output int                    mismatch_count
);

   localparam longint UNIT = longint'(1) << FRAC_BITS_DEFAULT;

   logic [CSR_W-1:0] model_width;
   logic [CSR_W-1:0] model_height;
   pixel_rsp_type    expected_colours[$];

   function automatic longint clip_coord(logic [PIX_W-1:0] p, logic [CSR_W-1:0] n);
      longint size;
      size = (n == 0) ? 1 : (n > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : longint'(n);
      return (((2 * longint'(p)) + 1) << FRAC_BITS_DEFAULT) / size - UNIT;
   endfunction

   // Weights carry one extra fraction bit, so one is 2 * UNIT.
   function automatic logic [CHAN_W-1:0] quantise(longint d);
      longint c;
      c = (d > 2 * UNIT) ? 2 * UNIT : d;
      return CHAN_W'((c * 255 + UNIT) >>> (FRAC_BITS_DEFAULT + 1));
   endfunction

   function automatic pixel_rsp_type shade_pixel(pixel_req_type p);
      longint px, py, d0, d1, d2;
      pixel_rsp_type r;
      px = clip_coord(p.pixel_x, model_width);
      py = clip_coord(p.pixel_y, model_height);
      d0 = UNIT - 2 * py;
      d1 = 2 * px + py + UNIT / 2;
      d2 = -2 * px + py + UNIT / 2;
      r.alpha = OPAQUE;
      if (d0 < 0 || d1 < 0 || d2 < 0) begin
         r.red = BACKGROUND;
         r.green = BACKGROUND;
         r.blue = BACKGROUND;
         r.covered = 1'b0;
      end else begin
         r.red = quantise(d0);
         r.green = quantise(d1);
         r.blue = quantise(d2);
         r.covered = 1'b1;
      end
      return r;
   endfunction

   assign colours_pending = expected_colours.size();

   always @(posedge clock) begin
      pixel_rsp_type want;
      if (reset) begin
         model_width <= WIDTH_RESET;
         model_height <= HEIGHT_RESET;
         expected_colours.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH) model_width <= csr_data;
            else model_height <= csr_data;
         end
         if (start && !busy) expected_colours.push_back(shade_pixel(req_data));
         if (rsp_valid) begin
            if (expected_colours.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("%0t: result word with none expected: %p", $realtime, rsp_data);
            end else begin
               want = expected_colours.pop_front();
               if (want.red !== rsp_data.red || want.green !== rsp_data.green
                   || want.blue !== rsp_data.blue || want.alpha !== rsp_data.alpha
                   || want.covered !== rsp_data.covered) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("%0t: colour mismatch, expected %p, got %p",
                              $realtime, want, rsp_data);
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

[tb/triangle_barycentric_pixel_shader_tb.sv]
// Stimulus and verdict for the triangle pixel shader.
// Depends on tbps_pkg, the block and pixel_colour_checker.
`timescale 1ns / 100ps
`default_nettype none
module triangle_barycentric_pixel_shader_tb
   import tbps_pkg::*;
();

   localparam int SETTLE_CYCLES = 48;
   localparam int STALL_LIMIT = 5000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   pixel_req_type    req_data;
   logic             rsp_valid;
   pixel_rsp_type    rsp_data;
   logic             csr_we;
   csr_index_type    csr_index;
   logic [CSR_W-1:0] csr_data;
   int               colours_pending;
   int               mismatch_count;
   int               quiet_cycles;
   int               idle_percent;
   logic [CSR_W-1:0] cur_width;
   logic [CSR_W-1:0] cur_height;

   triangle_barycentric_pixel_shader dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   pixel_colour_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_data(csr_data),
      .colours_pending(colours_pending), .mismatch_count(mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Leaves start high after acceptance, so back-to-back words need no toggle.
   task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
      int gap;
      if (idle_percent > 0 && $urandom_range(99, 0) < idle_percent) begin
         start <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{pixel_x: x, pixel_y: y};
      do @(posedge clock); while (busy);
   endtask

   // Lets the pipeline run dry before the sizes change.
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (colours_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(logic [CSR_W-1:0] w, logic [CSR_W-1:0] h);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data <= w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_width = w;
      cur_height = h;
   endtask

   function automatic logic [PIX_W-1:0] pick_coord(logic [CSR_W-1:0] n);
      int lim;
      lim = (n == 0) ? 1 : (n > 4096) ? 4096 : n;
      if ($urandom_range(99, 0) < 85) return PIX_W'($urandom_range(lim - 1, 0));
      return PIX_W'($urandom);
   endfunction

   function automatic logic [CSR_W-1:0] pick_size;
      int r;
      r = $urandom_range(99, 0);
      if (r < 70) return CSR_W'($urandom_range(64, 1));
      if (r < 90) return CSR_W'($urandom_range(4096, 65));
      return CSR_W'($urandom);
   endfunction

   initial begin
      int phase_idle[6];
      phase_idle = '{0, 69, 0, 37, 69, 0};
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data = '0;
      quiet_cycles = 0;
      idle_percent = 0;
      cur_width = WIDTH_RESET;
      cur_height = HEIGHT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Corners, centre, apex, pixels outside the frame, alternating bit patterns.
      send_pixel(0, 0);
      send_pixel(639, 479);
      send_pixel(320, 240);
      send_pixel(320, 120);
      send_pixel(160, 360);
      send_pixel(480, 360);
      send_pixel(4095, 4095);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      send_pixel(0, 479);
      set_frame(1, 1);
      send_pixel(0, 0);
      send_pixel(4095, 0);
      set_frame(0, 0);
      send_pixel(0, 0);
      send_pixel(1, 1);
      set_frame(13'h1FFF, 13'h1FFF);
      send_pixel(2048, 2048);
      send_pixel(2047, 1024);
      send_pixel(4095, 3071);
      set_frame(4096, 4096);
      send_pixel(2048, 3072);
      send_pixel(1024, 3072);
      set_frame(2, 3);
      send_pixel(0, 0);
      send_pixel(1, 2);

      for (int ph = 0; ph < 6; ph++) begin
         idle_percent = phase_idle[ph];
         for (int k = 0; k < 250; k++) begin
            if (k % 50 == 0) set_frame(pick_size(), pick_size());
            send_pixel(pick_coord(cur_width), pick_coord(cur_height));
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/tbps_pkg.sv
rtl/core/tbps_front.sv
rtl/core/tbps_queue.sv
rtl/core/tbps_divider.sv
rtl/core/tbps_shade.sv
rtl/core/triangle_barycentric_pixel_shader.sv
rtl/core/tbps_checker.sv
tb/pixel_colour_checker.sv
tb/triangle_barycentric_pixel_shader_tb.sv
